>>> rtl/core/ffc_pkg.sv
// Package for the full-convolution FIR filter: sizes, codes and shared types.
// Used by the channel interfaces, every module of the filter and its checker.
`timescale 1ns / 1ps
`default_nettype none

package ffc_pkg;

  localparam int TAPS         = 8;
  localparam int SAMPLE_WIDTH = 16;
  localparam int OUT_W        = 32;
  localparam int CFG_W        = 4;
  localparam int IDX_W        = 3;
  localparam int TAP_W        = $clog2(TAPS + 1);
  localparam int GROUP        = 4;
  localparam int NGROUPS      = (TAPS + GROUP - 1) / GROUP;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SAMPLE = 1'b1
  } ffc_cmd_t;

  typedef enum logic {
    ST_RUN,
    ST_FLUSH
  } ffc_state_t;

  typedef logic signed [SAMPLE_WIDTH-1:0] ffc_sample_t;
  typedef logic signed [OUT_W-1:0]        ffc_acc_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic load;
    logic use_tap;
  } ffc_cell_ctl_t;

  typedef struct packed {
    logic valid;
    logic last;
  } ffc_tag_t;

  typedef struct packed {
    logic     valid;
    logic     last;
    ffc_acc_t sum;
  } ffc_res_t;

endpackage

`default_nettype wire

>>> rtl/core/ffc_if.sv
// Valid/ready channel interfaces of the full-convolution FIR filter.
// Depends on ffc_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ffc_cfg_if import ffc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] tap_count;

  modport source (output valid, output tap_count, input ready);
  modport sink   (input valid, input tap_count, output ready);
endinterface

interface ffc_in_if import ffc_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic [IDX_W-1:0]               coef_index;
  logic signed [SAMPLE_WIDTH-1:0] value;
  logic                           end_of_input;

  modport source (output valid, output command, output coef_index, output value,
                  output end_of_input, input ready);
  modport sink   (input valid, input command, input coef_index, input value,
                  input end_of_input, output ready);
endinterface

interface ffc_out_if import ffc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] filter_output;
  logic                    end_of_output;

  modport source (output valid, output filter_output, output end_of_output, input ready);
  modport sink   (input valid, input filter_output, input end_of_output, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ffc_cell.sv
// One tap of the filter: a delay-line stage, its coefficient and a registered product.
// Depends on ffc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ffc_cell import ffc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  ffc_cell_ctl_t ctl,
  input  ffc_sample_t   coef_data,
  input  ffc_sample_t   sample_in,
  output ffc_sample_t   sample,
  output ffc_acc_t      product
);

  ffc_sample_t                      coef;
  ffc_sample_t                      coef_used;
  logic signed [2*SAMPLE_WIDTH-1:0] mult;

  assign coef_used = ctl.use_tap ? coef : '0;
  assign mult      = coef_used * sample_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef   <= '0;
      sample <= '0;
    end else begin
      if (ctl.load) begin
        coef <= coef_data;
      end
      if (ctl.shift) begin
        sample <= ctl.clear ? '0 : sample_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      product <= OUT_W'(mult);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ffc_adder.sv
// Two-stage adder tree that sums the tap products, wrapping at the output width.
// Depends on ffc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ffc_adder import ffc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  ffc_tag_t tag_in,
  input  ffc_acc_t products [TAPS],
  output ffc_res_t res
);

  ffc_acc_t group_sum  [NGROUPS];
  ffc_acc_t group_next [NGROUPS];
  ffc_tag_t tag_a;
  ffc_acc_t total;

  always_comb begin
    for (int g = 0; g < NGROUPS; g++) begin
      group_next[g] = '0;
    end
    for (int k = 0; k < TAPS; k++) begin
      group_next[k / GROUP] = group_next[k / GROUP] + products[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_a <= '0;
    end else if (en) begin
      tag_a <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      group_sum <= group_next;
    end
  end

  always_comb begin
    total = '0;
    for (int g = 0; g < NGROUPS; g++) begin
      total = total + group_sum[g];
    end
  end

  assign res = '{valid: tag_a.valid, last: tag_a.last, sum: total};

endmodule

`default_nettype wire

>>> rtl/core/ffc_out_buf.sv
// Output register with a skid stage, so that the pipeline stops in the cycle after a stall.
// Depends on ffc_pkg and the result channel interface.
`timescale 1ns / 1ps
`default_nettype none

module ffc_out_buf import ffc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  ffc_res_t  res,
  output logic      en,
  ffc_out_if.source result
);

  logic     out_valid;
  ffc_acc_t out_sum;
  logic     out_last;
  logic     skid_valid;
  ffc_acc_t skid_sum;
  logic     skid_last;
  logic     take;

  assign en   = !skid_valid;
  assign take = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res.valid;
      end
    end else if (res.valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (skid_valid) begin
        out_sum  <= skid_sum;
        out_last <= skid_last;
      end else if (res.valid) begin
        out_sum  <= res.sum;
        out_last <= res.last;
      end
    end else if (res.valid && !skid_valid) begin
      skid_sum  <= res.sum;
      skid_last <= res.last;
    end
  end

  assign result.valid         = out_valid;
  assign result.filter_output = out_sum;
  assign result.end_of_output = out_last;

endmodule

`default_nettype wire

>>> rtl/core/fir_full_convolution.sv
// Top level of the full-convolution FIR filter: control, the row of tap cells,
// the adder tree and the output buffer. Depends on ffc_pkg, the interfaces and all submodules.
//
//   channel   modport  payload                                   transfer
//   cfg       sink     tap_count                                 valid && ready
//   stream    sink     command, coef_index, value, end_of_input  valid && ready
//   result    source   filter_output, end_of_output              valid && ready
//
// A coefficient load or a sample is taken every cycle, but not while a tail is flushed or the
// result channel stalls; each result passes through the product, tree and output registers.
// A sample marked last, when more than one tap is in use, holds the input while the tail
// is shifted out, and for longer when the result channel stalls.
// Synchronous reset clears the coefficients, the delay line, tap_count (to 1) and all valid bits.
// A stalled result stops the pipeline from the next cycle on, through the skid stage.
`timescale 1ns / 1ps
`default_nettype none

module fir_full_convolution import ffc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  ffc_cfg_if.sink   cfg,
  ffc_in_if.sink    stream,
  ffc_out_if.source result
);

  logic [CFG_W-1:0] tap_count;
  logic [TAP_W-1:0] n;
  logic [TAP_W-1:0] cnt;
  logic [TAP_W-1:0] cnt_next;
  ffc_state_t       state;
  ffc_state_t       state_next;
  logic             en;
  logic             in_ready;
  logic             in_acc;
  logic             flush_done;
  logic             shift;
  logic             clear;
  logic             op_last;
  logic             load_acc;
  ffc_sample_t      sample_in;
  ffc_tag_t         p_tag;
  ffc_res_t         res;
  ffc_cell_ctl_t    ctl      [TAPS];
  ffc_sample_t      taps     [TAPS];
  ffc_acc_t         products [TAPS];

  assign cfg.ready    = 1'b1;
  assign stream.ready = in_ready;
  assign in_acc       = stream.valid && in_ready;
  assign load_acc     = in_acc && (stream.command == CMD_LOAD);
  assign flush_done   = (cnt == n - TAP_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= CFG_W'(1);
    end else if (cfg.valid) begin
      tap_count <= cfg.tap_count;
    end
  end

  always_comb begin
    if (tap_count == '0) begin
      n = TAP_W'(1);
    end else if (32'(tap_count) > TAPS) begin
      n = TAP_W'(TAPS);
    end else begin
      n = TAP_W'(tap_count);
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_RUN: begin
        cnt_next = TAP_W'(1);
        if (in_acc && stream.command == CMD_SAMPLE && stream.end_of_input &&
            n != TAP_W'(1)) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (en) begin
          cnt_next = cnt + TAP_W'(1);
          if (flush_done) begin
            state_next = ST_RUN;
          end
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    shift     = 1'b0;
    op_last   = 1'b0;
    sample_in = '0;
    unique case (state)
      ST_RUN: begin
        in_ready  = en;
        sample_in = stream.value;
        shift     = in_acc && (stream.command == CMD_SAMPLE);
        op_last   = stream.end_of_input && (n == TAP_W'(1));
      end
      ST_FLUSH: begin
        shift   = en;
        op_last = flush_done;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    clear = op_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      cnt   <= TAP_W'(1);
      p_tag <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (en) begin
        p_tag <= '{valid: shift, last: op_last};
      end
    end
  end

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    assign ctl[k] = '{shift:   shift,
                      clear:   clear,
                      load:    load_acc && (32'(stream.coef_index) == k),
                      use_tap: (32'(n) > k)};

    if (k == 0) begin : g_head
      ffc_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl[k]),
        .coef_data (stream.value),
        .sample_in (sample_in),
        .sample    (taps[k]),
        .product   (products[k])
      );
    end else begin : g_body
      ffc_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl[k]),
        .coef_data (stream.value),
        .sample_in (taps[k-1]),
        .sample    (taps[k]),
        .product   (products[k])
      );
    end
  end

  ffc_adder u_adder (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .tag_in   (p_tag),
    .products (products),
    .res      (res)
  );

  ffc_out_buf u_out_buf (
    .clk    (clk),
    .rst    (rst),
    .res    (res),
    .en     (en),
    .result (result)
  );

endmodule

`default_nettype wire

>>> rtl/core/ffc_checker.sv
// Port-level checker for the full-convolution FIR filter, bound to the top level.
// Depends on ffc_pkg and the top level's channel ports.
`timescale 1ns / 1ps
`default_nettype none

module ffc_checker import ffc_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    cfg_valid,
  input logic                    cfg_ready,
  input logic [CFG_W-1:0]        cfg_tap,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    in_command,
  input logic                    in_end,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [OUT_W-1:0] out_data,
  input logic                    out_end
);

  logic [CFG_W-1:0] shadow_tap;

  always_ff @(posedge clk) begin
    if (rst) begin
      shadow_tap <= CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      shadow_tap <= cfg_tap;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before its transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data) && $stable(out_end))
    else $error("result payload changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered straight after reset");

  a_tail_holds_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_command == CMD_SAMPLE) && in_end &&
    (shadow_tap > CFG_W'(1)) |=> !in_ready)
    else $error("input taken during the tail of a sequence");

endmodule

bind fir_full_convolution ffc_checker u_ffc_checker (
  .clk        (clk),
  .rst        (rst),
  .cfg_valid  (cfg.valid),
  .cfg_ready  (cfg.ready),
  .cfg_tap    (cfg.tap_count),
  .in_valid   (stream.valid),
  .in_ready   (stream.ready),
  .in_command (stream.command),
  .in_end     (stream.end_of_input),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .out_data   (result.filter_output),
  .out_end    (result.end_of_output)
);

`default_nettype wire

>>> tb/fir_full_convolution_tb.sv
`timescale 1ns / 1ps
// Testbench for fir_full_convolution: directed and random coefficient loads and sample runs,
// each output checked against a convolution predictor kept inside the bench.
// Depends on ffc_pkg, the ffc channel interfaces and the filter RTL.

module fir_full_convolution_tb import ffc_pkg::*; ();

  localparam int SETTLE_CYCLES = 12;

  typedef struct packed {
    ffc_acc_t sum;
    logic     last;
  } conv_out_t;

  logic clk = 1'b0;
  logic rst;

  ffc_cfg_if cfg_ch ();
  ffc_in_if  in_ch ();
  ffc_out_if out_ch ();

  fir_full_convolution u_dut (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_ch),
    .stream(in_ch),
    .result(out_ch)
  );

  ffc_sample_t      coef_bank [TAPS];
  ffc_sample_t      history   [TAPS];
  logic [CFG_W-1:0] taps_reg;
  conv_out_t        expected_conv [$];
  int               mismatches;
  int               send_idle_pct;
  int               recv_stall_pct;

  always #5 clk = ~clk;

  function automatic void shift_history(ffc_sample_t s);
    for (int i = TAPS - 1; i > 0; i--) history[i] = history[i - 1];
    history[0] = s;
  endfunction

  function automatic ffc_acc_t tap_sum(int n);
    ffc_acc_t acc;
    acc = '0;
    for (int k = 0; k < n; k++) acc += ffc_acc_t'(coef_bank[k]) * ffc_acc_t'(history[k]);
    return acc;
  endfunction

  function automatic void convolve_item(ffc_cmd_t cmd, logic [IDX_W-1:0] idx, ffc_sample_t val,
                                        logic eoi);
    int n;
    n = (taps_reg == 0) ? 1 : (taps_reg > TAPS) ? TAPS : int'(taps_reg);
    if (cmd == CMD_LOAD) begin
      coef_bank[idx] = val;
      return;
    end
    shift_history(val);
    expected_conv.push_back('{tap_sum(n), eoi && n == 1});
    if (eoi) begin
      for (int t = 1; t < n; t++) begin
        shift_history('0);
        expected_conv.push_back('{tap_sum(n), t == n - 1});
      end
      foreach (history[i]) history[i] = '0;
    end
  endfunction

  // Outputs are checked before the inputs of the same edge are predicted, so the order of
  // the transfers within one edge cannot matter.
  always @(posedge clk) begin : monitor
    conv_out_t want;
    if (rst) begin
      foreach (coef_bank[i]) coef_bank[i] = '0;
      foreach (history[i]) history[i] = '0;
      taps_reg = CFG_W'(1);
      expected_conv.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_conv.size() == 0) begin
          mismatches++;
          $display("%0t: output with none expected: filter_output %0d end_of_output %0b",
                   $time, out_ch.filter_output, out_ch.end_of_output);
        end else begin
          want = expected_conv.pop_front();
          if (out_ch.filter_output !== want.sum || out_ch.end_of_output !== want.last) begin
            mismatches++;
            $display("%0t: expected filter_output %0d end_of_output %0b, got %0d %0b",
                     $time, want.sum, want.last, out_ch.filter_output, out_ch.end_of_output);
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) taps_reg = cfg_ch.tap_count;
      if (in_ch.valid && in_ch.ready)
        convolve_item(ffc_cmd_t'(in_ch.command), in_ch.coef_index, in_ch.value,
                      in_ch.end_of_input);
    end
  end

  always @(posedge clk) out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

  task automatic send_item(ffc_cmd_t cmd, logic [IDX_W-1:0] idx, ffc_sample_t val, logic eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= cmd;
    in_ch.coef_index   <= idx;
    in_ch.value        <= val;
    in_ch.end_of_input <= eoi;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic wait_for_outputs();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_conv.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_taps(logic [CFG_W-1:0] n);
    wait_for_outputs();
    cfg_ch.valid     <= 1'b1;
    cfg_ch.tap_count <= n;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic ffc_sample_t pick_value();
    case ($urandom_range(5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      default: return ffc_sample_t'($urandom);
    endcase
  endfunction

  task automatic test_after_reset();
    send_item(CMD_SAMPLE, '0, 16'sh7fff, 1'b0);
    send_item(CMD_SAMPLE, '0, 16'sh8000, 1'b1);
  endtask

  task automatic test_single_tap();
    send_item(CMD_LOAD, '0, 16'sh8000, 1'b0);
    send_item(CMD_SAMPLE, '0, 16'sh8000, 1'b0);
    send_item(CMD_SAMPLE, '0, 16'sh7fff, 1'b1);
  endtask

  task automatic test_full_extremes();
    write_taps(CFG_W'(TAPS));
    for (int i = 0; i < TAPS; i++)
      send_item(CMD_LOAD, IDX_W'(i), (i % 3 == 1) ? 16'sh7fff : 16'sh8000, i[0]);
    send_item(CMD_SAMPLE, '0, 16'sh8000, 1'b0);
    send_item(CMD_SAMPLE, '1, 16'sh8000, 1'b0);
    send_item(CMD_SAMPLE, '0, 16'sh7fff, 1'b0);
    send_item(CMD_SAMPLE, '0, -16'sd1, 1'b1);
  endtask

  // A tap count of zero acts as one tap, and anything above the tap total as the full set.
  task automatic test_tap_clamp();
    write_taps('0);
    send_item(CMD_SAMPLE, '0, 16'sd1, 1'b1);
    write_taps('1);
    send_item(CMD_SAMPLE, '0, 16'sh8000, 1'b1);
    write_taps(CFG_W'(TAPS + 1));
    send_item(CMD_SAMPLE, '0, 16'sh7fff, 1'b1);
    write_taps(CFG_W'(2));
    send_item(CMD_SAMPLE, '0, 16'sh8000, 1'b1);
  endtask

  task automatic test_random_stream(int n_items, int idle_pct, int stall_pct,
                                    logic [CFG_W-1:0] taps);
    int sent;
    int run_len;
    bit close_run;
    bit paused;
    write_taps(taps);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      if (!paused && sent >= n_items / 2) begin
        wait_for_outputs();
        paused = 1'b1;
      end
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          send_item(CMD_LOAD, IDX_W'($urandom_range(7)), pick_value(), 1'($urandom_range(1)));
          sent++;
        end
      end else begin
        run_len   = $urandom_range(1, 10);
        close_run = ($urandom_range(9) != 0);
        for (int i = 0; i < run_len; i++) begin
          send_item(CMD_SAMPLE, IDX_W'($urandom_range(7)), pick_value(),
                    close_run && i == run_len - 1);
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst                <= 1'b1;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.tap_count   <= CFG_W'(1);
    in_ch.valid        <= 1'b0;
    in_ch.command      <= CMD_LOAD;
    in_ch.coef_index   <= '0;
    in_ch.value        <= '0;
    in_ch.end_of_input <= 1'b0;
    mismatches     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_after_reset();
    test_single_tap();
    test_full_extremes();
    test_tap_clamp();
    test_random_stream(80, 0, 0, CFG_W'(TAPS));
    test_random_stream(80, 73, 0, CFG_W'(1));
    test_random_stream(80, 0, 73, CFG_W'($urandom_range(2, TAPS - 1)));
    test_random_stream(70, 12, 12, CFG_W'(TAPS));
    wait_for_outputs();

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
